// ===== rtl/jfps_pkg.sv =====
package jfps_pkg;

  localparam int MAX_COLS   = 1024;
  localparam int MAX_ROWS   = 1024;
  localparam int VALUE_W    = 16;
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COL_CNT_W  = $clog2(MAX_COLS + 1);
  localparam int ROW_CNT_W  = $clog2(MAX_ROWS + 1);
  localparam int CFG_SIZE_W = 11;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int OUT_DATA_W = VALUE_W + ROW_W + COL_W;
  localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;
  localparam int IN_TDATA_W  = ((VALUE_W + 7) / 8) * 8;

  localparam logic signed [VALUE_W-1:0] BOUNDARY_RESET = VALUE_W'(25600);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOUNDARY = 2'd0,
    REG_ROWS     = 2'd1,
    REG_COLS     = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    OP_CELL  = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  // what the second stage does with an item
  typedef enum logic [1:0] {
    JOB_GRID_QUIET = 2'd0,
    JOB_GRID_EMIT  = 2'd1,
    JOB_FLUSH_EMIT = 2'd2
  } job_e;

  typedef struct packed {
    job_e             job;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
    logic             top_bnd;
    logic             left_bnd;
    logic             right_bnd;
  } job_t;

  // clamp a written size to [2, maxv]
  function automatic int clamp_size(input logic [CFG_SIZE_W-1:0] v, input int maxv);
    int r;
    r = int'(v);
    if (r < 2) begin
      r = 2;
    end else if (r > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

endpackage

// ===== rtl/jacobi_five_point_sweep.sv =====
// one jacobi sweep of a five-point heat stencil over a grid streamed in raster order
//
// slave stream: cell values (tdata) in raster order, tuser selects grid cell (0) or
// flush item (1). after rows x cols cells, one flush per column drains the last row.
// master stream: one transfer per result, lagging the input by one row; tdata holds
// new_value, row_index and col_index, tlast marks the final cell of the sweep.
// cells of row 0, cells after the grid is complete and early flushes give no transfer.
// config channel: always ready; index 0 boundary value, 1 rows, 2 columns. writing
// a size restarts the sweep. write only while idle.
//
// throughput: one item per cycle while the master side keeps taking results, set by the three
// line buffer memories (each one read and one write port per cycle). a result is offered on
// the master side once the item has passed the line buffer read and the output register.
// when the master side stalls, the output register holds its result, the second stage
// holds one more item and the slave side stalls after that.
// reset: counters return to the start of a sweep, boundary value 100.0, sizes 1024.
// line buffers have no reset and need no clearing pass: every entry is written
// before its value is used in in-order streaming.
module jacobi_five_point_sweep (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // slave stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [jfps_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // [15:0] cell_value
  input  logic                                  s_axis_tuser,  // [0] operation
  // master stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [15:0] new_value, [25:16] row_index, [35:26] col_index, [39:36] zero
  output logic [jfps_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                                  m_axis_tlast,
  // configuration writes
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [jfps_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [jfps_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import jfps_pkg::*;

  // ---------------------------------------------------------------- config
  logic signed [VALUE_W-1:0]   bnd_q;
  logic [ROW_CNT_W-1:0]        rows_q;
  logic [COL_CNT_W-1:0]        cols_q;
  logic                        cfg_fire;
  logic                        size_write;
  cfg_reg_e                    cfg_reg;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign cfg_reg     = cfg_reg_e'(cfg_index_i);

  always_comb begin
    size_write = 1'b0;
    case (cfg_reg)
      REG_ROWS: size_write = cfg_fire;
      REG_COLS: size_write = cfg_fire;
      default:  size_write = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bnd_q  <= BOUNDARY_RESET;
      rows_q <= ROW_CNT_W'(MAX_ROWS);
      cols_q <= COL_CNT_W'(MAX_COLS);
    end else if (cfg_fire) begin
      case (cfg_reg)
        REG_BOUNDARY: bnd_q  <= cfg_data_i[VALUE_W-1:0];
        REG_ROWS:     rows_q <= ROW_CNT_W'(clamp_size(cfg_data_i[CFG_SIZE_W-1:0], MAX_ROWS));
        REG_COLS:     cols_q <= COL_CNT_W'(clamp_size(cfg_data_i[CFG_SIZE_W-1:0], MAX_COLS));
        default:      ;  // index beyond the register list is ignored
      endcase
    end
  end

  // ---------------------------------------------------------------- stage a: position
  logic [ROW_CNT_W-1:0] in_row_q, in_row_d;
  logic [COL_W-1:0]     in_col_q, in_col_d;
  logic [COL_W-1:0]     flush_col_q, flush_col_d;
  logic                 in_fire;
  logic                 is_flush;
  logic                 complete;
  logic                 grid_ok, flush_ok;
  logic                 col_last, flush_last;
  logic                 job_load;
  job_t                 job_a;

  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign is_flush   = (op_e'(s_axis_tuser) == OP_FLUSH);
  assign complete   = (in_row_q >= rows_q);
  assign grid_ok    = !complete && (COL_CNT_W'(in_col_q) < cols_q);
  assign flush_ok   = complete && (COL_CNT_W'(flush_col_q) < cols_q);
  assign col_last   = (COL_CNT_W'(in_col_q) + COL_CNT_W'(1)) >= cols_q;
  assign flush_last = (COL_CNT_W'(flush_col_q) + COL_CNT_W'(1)) >= cols_q;
  assign job_load   = in_fire && (is_flush ? flush_ok : grid_ok);

  always_comb begin
    in_row_d    = in_row_q;
    in_col_d    = in_col_q;
    flush_col_d = flush_col_q;
    if (size_write) begin
      // new size restarts the sweep
      in_row_d    = '0;
      in_col_d    = '0;
      flush_col_d = '0;
    end else if (in_fire && !is_flush && grid_ok) begin
      if (col_last) begin
        in_col_d = '0;
        in_row_d = in_row_q + ROW_CNT_W'(1);
      end else begin
        in_col_d = in_col_q + COL_W'(1);
      end
    end else if (in_fire && is_flush && flush_ok) begin
      if (flush_last) begin
        in_row_d    = '0;
        in_col_d    = '0;
        flush_col_d = '0;
      end else begin
        flush_col_d = flush_col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q    <= '0;
      in_col_q    <= '0;
      flush_col_q <= '0;
    end else begin
      in_row_q    <= in_row_d;
      in_col_q    <= in_col_d;
      flush_col_q <= flush_col_d;
    end
  end

  always_comb begin
    if (is_flush) begin
      job_a.job       = JOB_FLUSH_EMIT;
      job_a.col       = flush_col_q;
      job_a.row       = ROW_W'(rows_q - ROW_CNT_W'(1));
      job_a.last      = flush_last;
      job_a.top_bnd   = 1'b0;
      job_a.left_bnd  = (flush_col_q == '0);
      job_a.right_bnd = flush_last;
    end else begin
      job_a.job       = (in_row_q == '0) ? JOB_GRID_QUIET : JOB_GRID_EMIT;
      job_a.col       = in_col_q;
      job_a.row       = ROW_W'(in_row_q - ROW_CNT_W'(1));
      job_a.last      = 1'b0;
      job_a.top_bnd   = (in_row_q == ROW_CNT_W'(1));
      job_a.left_bnd  = (in_col_q == '0);
      job_a.right_bnd = col_last;
    end
  end

  // line buffer read addresses: middle row at c (or c-1 for flush) and c+1,
  // upper row at c
  logic [COL_W-1:0] rd_col;
  logic [COL_W-1:0] addr_a, addr_b;

  assign rd_col = is_flush ? flush_col_q : in_col_q;
  assign addr_a = is_flush ? (flush_col_q - COL_W'(1)) : in_col_q;
  assign addr_b = rd_col + COL_W'(1);

  // ---------------------------------------------------------------- stage b: stencil
  logic                       s1_valid_q, s1_valid_d;
  job_t                       job_q;
  logic signed [VALUE_W-1:0]  x_q;
  logic                       advance;
  logic                       wr_en;
  logic [COL_W-1:0]           wr_addr;
  logic [VALUE_W-1:0]         rd_a, rd_b, rd_up;
  logic                       byp_a_q, byp_b_q, byp_up_q;
  logic [VALUE_W-1:0]         wd_mid_q, wd_up_q;
  logic signed [VALUE_W-1:0]  mid_a, mid_b, up_v;
  logic signed [VALUE_W-1:0]  left_q;
  logic signed [VALUE_W-1:0]  top_v, down_v, left_v, right_v;
  logic signed [VALUE_W+1:0]  sum4;
  logic signed [VALUE_W-1:0]  avg;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || advance;
  assign wr_en         = s1_valid_q && advance && (job_q.job != JOB_FLUSH_EMIT);
  assign wr_addr       = job_q.col;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s_axis_tready) begin
      s1_valid_d = job_load;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      job_q    <= job_a;
      x_q      <= s_axis_tdata[VALUE_W-1:0];
      // a write in the read cycle is not seen by the read-first memory
      byp_a_q  <= wr_en && (wr_addr == addr_a);
      byp_b_q  <= wr_en && (wr_addr == addr_b);
      byp_up_q <= wr_en && (wr_addr == rd_col);
      wd_mid_q <= x_q;
      wd_up_q  <= mid_a;
    end
  end

  assign mid_a = byp_a_q  ? wd_mid_q : rd_a;
  assign mid_b = byp_b_q  ? wd_mid_q : rd_b;
  assign up_v  = byp_up_q ? wd_up_q  : rd_up;

  // middle row kept twice for two read ports
  jfps_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_COLS)) u_mid_a (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (x_q),
    .re_i    (in_fire),
    .raddr_i (addr_a),
    .rdata_o (rd_a)
  );

  jfps_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_COLS)) u_mid_b (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (x_q),
    .re_i    (in_fire),
    .raddr_i (addr_b),
    .rdata_o (rd_b)
  );

  jfps_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_COLS)) u_upper (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (mid_a),
    .re_i    (in_fire),
    .raddr_i (rd_col),
    .rdata_o (rd_up)
  );

  // old middle value one column to the left
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else if (wr_en) begin
      left_q <= mid_a;
    end
  end

  always_comb begin
    if (job_q.job == JOB_FLUSH_EMIT) begin
      top_v  = up_v;
      down_v = bnd_q;
      left_v = job_q.left_bnd ? bnd_q : mid_a;
    end else begin
      top_v  = job_q.top_bnd ? bnd_q : up_v;
      down_v = x_q;
      left_v = job_q.left_bnd ? bnd_q : left_q;
    end
    right_v = job_q.right_bnd ? bnd_q : mid_b;
  end

  // round to nearest: add 2, arithmetic shift by 2; always fits the value width
  assign sum4 = (VALUE_W+2)'(top_v) + (VALUE_W+2)'(down_v) + (VALUE_W+2)'(left_v)
              + (VALUE_W+2)'(right_v) + (VALUE_W+2)'(2);
  assign avg  = sum4[VALUE_W+1:2];

  // ---------------------------------------------------------------- output register
  logic                  out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic                  out_last_q;

  always_comb begin
    out_valid_d = m_axis_tvalid;
    if (advance) begin
      out_valid_d = s1_valid_q && (job_q.job != JOB_GRID_QUIET);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      m_axis_tvalid <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      out_data_q <= {job_q.col, job_q.row, avg};
      out_last_q <= job_q.last;
    end
  end

  assign m_axis_tdata = OUT_TDATA_W'(out_data_q);
  assign m_axis_tlast = out_last_q;

endmodule

// ===== rtl/jfps_ram.sv =====
module jfps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read-first, data held while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== tb/sv/tb_jacobi_five_point_sweep.sv =====
`timescale 1ns / 1ps

module tb_jacobi_five_point_sweep;
  import jfps_pkg::*;

  // index with no register behind it, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  // run is about 700 items with gaps and stalls, plus drains
  localparam int unsigned CYCLE_LIMIT = 100_000;
  localparam int RANDOM_ITEMS = 580;
  localparam int QUIET_AFTER = 480;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [ROW_W-1:0]          row;
    logic [COL_W-1:0]          col;
    logic                      last;
  } cell_result_t;

  // one line of the opening stimulus: a register write or a stream item
  typedef struct {
    bit                    is_write;
    logic [CFG_IDX_W-1:0]  reg_idx;
    op_e                   op;
    logic [15:0]           data;
    bit                    pinned;
    cell_result_t          want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata;
  logic s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  jacobi_five_point_sweep dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // stencil predictor state: two line buffers plus the raster position
  logic signed [VALUE_W-1:0] upper_line [0:MAX_COLS-1];
  logic signed [VALUE_W-1:0] middle_line [0:MAX_COLS-1];
  logic signed [VALUE_W-1:0] left_prev = '0;
  int unsigned in_row = 0;
  int unsigned in_col = 0;
  int unsigned flush_pos = 0;
  logic signed [VALUE_W-1:0] edge_temp = BOUNDARY_RESET;
  logic [CFG_SIZE_W-1:0] rows_cfg = CFG_SIZE_W'(MAX_ROWS);
  logic [CFG_SIZE_W-1:0] cols_cfg = CFG_SIZE_W'(MAX_COLS);

  cell_result_t pending_cells [$];
  stim_row_t opening_rows [$];

  int unsigned cycle_count = 0;
  int in_transfers = 0;
  int out_transfers = 0;
  int sweeps_closed = 0;
  int mismatches = 0;
  bit quiet = 0;
  int tx_calm = 0;
  int rx_hold = 0;
  int rx_calm = 0;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // sizes outside [2, max] are pulled back into range when used
  function automatic int unsigned fit_size(input logic [CFG_SIZE_W-1:0] v, input int maxv);
    int unsigned n;
    n = v;
    if (n < 2) n = 2;
    if (n > maxv) n = maxv;
    return n;
  endfunction

  // rounded mean of four q8.8 values, floor shift after adding two
  function automatic logic signed [VALUE_W-1:0] mean_of_four(
      input logic signed [VALUE_W-1:0] a, input logic signed [VALUE_W-1:0] b,
      input logic signed [VALUE_W-1:0] c, input logic signed [VALUE_W-1:0] d);
    logic signed [VALUE_W+2:0] s;
    s = a + b + c + d + 19'sd2;
    s = s >>> 2;
    return s[VALUE_W-1:0];
  endfunction

  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    case (idx)
      REG_BOUNDARY: edge_temp = data;
      REG_ROWS, REG_COLS: begin
        if (idx == REG_ROWS) rows_cfg = data[CFG_SIZE_W-1:0];
        else cols_cfg = data[CFG_SIZE_W-1:0];
        // a size change restarts the sweep
        in_row = 0;
        in_col = 0;
        flush_pos = 0;
      end
      default: ;
    endcase
  endtask

  // advance the stencil by one accepted item, made says if a result follows
  task automatic stencil_step(input op_e op, input logic signed [VALUE_W-1:0] x,
                              output bit made, output cell_result_t res);
    int unsigned nrows, ncols, c;
    logic signed [VALUE_W-1:0] up, lf, rt;
    bit complete;
    nrows = fit_size(rows_cfg, MAX_ROWS);
    ncols = fit_size(cols_cfg, MAX_COLS);
    complete = in_row >= nrows;
    made = 0;
    res = '0;
    if (op == OP_CELL) begin
      // cells after the grid is complete are dropped
      if (!complete && in_col < ncols) begin
        c = in_col;
        if (in_row >= 1) begin
          up = (in_row == 1) ? edge_temp : upper_line[c];
          lf = (c == 0) ? edge_temp : left_prev;
          rt = (c + 1 < ncols) ? middle_line[c+1] : edge_temp;
          res.value = mean_of_four(up, x, lf, rt);
          res.row = ROW_W'(in_row - 1);
          res.col = COL_W'(c);
          res.last = 1'b0;
          made = 1;
        end
        left_prev = middle_line[c];
        upper_line[c] = middle_line[c];
        middle_line[c] = x;
        in_col++;
        if (in_col >= ncols) begin
          in_col = 0;
          in_row++;
        end
      end
    end else if (complete && flush_pos < ncols) begin
      // flush drains the bottom row with the boundary below it
      c = flush_pos;
      up = upper_line[c];
      lf = (c == 0) ? edge_temp : middle_line[c-1];
      rt = (c + 1 < ncols) ? middle_line[c+1] : edge_temp;
      res.value = mean_of_four(up, edge_temp, lf, rt);
      res.row = ROW_W'(nrows - 1);
      res.col = COL_W'(c);
      res.last = (c + 1 >= ncols);
      made = 1;
      if (res.last) begin
        in_row = 0;
        in_col = 0;
        flush_pos = 0;
      end else begin
        flush_pos = c + 1;
      end
    end
  endtask

  // drop tvalid and wait until every predicted result is back
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk_i);
    // row 0 cells produce nothing but may still sit in the pipeline
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    drain_results();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_write(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // one slave transfer, optional gap first; a pinned row overrides the prediction
  task automatic push_item(input op_e op, input logic [15:0] val, input bit pin,
                           input cell_result_t pinned_res);
    int gap;
    bit made;
    cell_result_t res;
    gap = 0;
    if (!quiet) begin
      if (tx_calm > 0) tx_calm--;
      else if ($urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
      else if ($urandom_range(0, 15) == 0) tx_calm = $urandom_range(20, 60);
    end
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= val;
    do @(posedge clk_i); while (!s_axis_tready);
    in_transfers++;
    stencil_step(op, val, made, res);
    if (made) pending_cells.push_back(pin ? pinned_res : res);
  endtask

  // one sweep setting, then items that follow the raster order with a little noise
  task automatic run_phase(input logic [15:0] bnd, input logic [15:0] rows_w,
                           input logic [15:0] cols_w, input bit resize, input int sweeps,
                           input bit cut, output int sent);
    int total;
    bit noisy;
    op_e op;
    logic [15:0] val;
    write_reg(REG_BOUNDARY, bnd);
    if (resize) begin
      write_reg(REG_ROWS, rows_w);
      write_reg(REG_COLS, cols_w);
    end
    total = sweeps * (fit_size(rows_cfg, MAX_ROWS) + 1) * fit_size(cols_cfg, MAX_COLS);
    // a cut phase leaves the sweep half done for the next size write to abort
    if (cut) total = $urandom_range(1, total - 1);
    sent = 0;
    while (sent < total) begin
      noisy = ($urandom_range(0, 19) == 0);
      op = ((in_row >= fit_size(rows_cfg, MAX_ROWS)) ^ noisy) ? OP_FLUSH : OP_CELL;
      case ($urandom_range(0, 7))
        0: val = 16'h7FFF;
        1: val = 16'h8000;
        default: val = 16'($urandom);
      endcase
      push_item(op, val, 1'b0, '0);
      if (!noisy) sent++;
    end
  endtask

  task automatic report(input string what, input cell_result_t want, input cell_result_t got);
    if (mismatches < 10)
      $display("%s: want value %0d row %0d col %0d last %0b, got value %0d row %0d col %0d last %0b",
               what, want.value, want.row, want.col, want.last,
               got.value, got.row, got.col, got.last);
    mismatches++;
  endtask

  task automatic tab_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    stim_row_t r;
    r = '{is_write: 1, reg_idx: idx, op: OP_CELL, data: data, pinned: 0, want: '0};
    opening_rows.push_back(r);
  endtask

  task automatic tab_item(input op_e op, input logic [15:0] data);
    stim_row_t r;
    r = '{is_write: 0, reg_idx: REG_BOUNDARY, op: op, data: data, pinned: 0, want: '0};
    opening_rows.push_back(r);
  endtask

  task automatic tab_pin(input op_e op, input logic [15:0] data, input logic [15:0] value,
                         input int row, input int col, input bit last);
    stim_row_t r;
    r = '{is_write: 0, reg_idx: REG_BOUNDARY, op: op, data: data, pinned: 1, want: '0};
    r.want.value = value;
    r.want.row = ROW_W'(row);
    r.want.col = COL_W'(col);
    r.want.last = last;
    opening_rows.push_back(r);
  endtask

  // master side: stall bursts, calm stretches, none at all near the end
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (quiet) begin
      m_axis_tready <= 1'b1;
    end else if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else if (rx_calm > 0) begin
      rx_calm--;
      m_axis_tready <= 1'b1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          rx_hold = $urandom_range(1, 9) - 1;
          m_axis_tready <= 1'b0;
        end
        3: begin
          rx_calm = $urandom_range(20, 80);
          m_axis_tready <= 1'b1;
        end
        default: m_axis_tready <= 1'b1;
      endcase
    end
  end

  // result checker and run watchdog
  always @(posedge clk_i) begin
    cell_result_t got, want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_cells.size());
      $display("[FAIL] regression broken");
      $finish;
    end else if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.value = m_axis_tdata[VALUE_W-1:0];
      got.row = m_axis_tdata[VALUE_W +: ROW_W];
      got.col = m_axis_tdata[VALUE_W+ROW_W +: COL_W];
      got.last = m_axis_tlast;
      out_transfers++;
      if (got.last) sweeps_closed++;
      if (pending_cells.size() == 0) begin
        report("result with nothing expected", '0, got);
      end else begin
        want = pending_cells.pop_front();
        if (got !== want) report("result mismatch", want, got);
      end
    end
  end

  initial begin
    int n;
    int random_items;
    bit resize;
    logic [15:0] bnd, rows_w, cols_w;

    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_BOUNDARY;
    cfg_data_i = '0;

    // hottest value everywhere: every cell and its mean stay at the maximum
    tab_write(REG_BOUNDARY, 16'h7FFF);
    tab_write(REG_ROWS, 16'd1);                 // below range, becomes 2
    tab_write(REG_COLS, 16'd0);                 // below range, becomes 2
    tab_item(OP_FLUSH, 16'hFFFF);               // flush before the grid is complete
    tab_item(OP_CELL, 16'h7FFF);
    tab_item(OP_CELL, 16'h7FFF);
    tab_pin(OP_CELL, 16'h7FFF, 16'h7FFF, 0, 0, 0);
    tab_pin(OP_CELL, 16'h7FFF, 16'h7FFF, 0, 1, 0);
    tab_item(OP_CELL, 16'h0000);                // cell after the grid is complete
    tab_pin(OP_FLUSH, 16'h0000, 16'h7FFF, 1, 0, 0);
    tab_pin(OP_FLUSH, 16'h0000, 16'h7FFF, 1, 1, 1);
    // coldest value everywhere, rounding floors toward the minimum
    tab_write(REG_BOUNDARY, 16'h8000);
    tab_item(OP_CELL, 16'h8000);
    tab_item(OP_CELL, 16'h8000);
    tab_pin(OP_CELL, 16'h8000, 16'h8000, 0, 0, 0);
    tab_pin(OP_CELL, 16'h8000, 16'h8000, 0, 1, 0);
    tab_pin(OP_FLUSH, 16'h8000, 16'h8000, 1, 0, 0);
    tab_pin(OP_FLUSH, 16'h8000, 16'h8000, 1, 1, 1);
    tab_write(REG_SPARE, 16'h1234);             // no register there
    tab_write(REG_COLS, 16'hF803);              // bits above the size field ignored
    tab_item(OP_CELL, 16'h1234);
    tab_item(OP_CELL, 16'hEDCB);
    tab_write(REG_ROWS, 16'd2);                 // aborts the half-fed sweep
    tab_write(REG_BOUNDARY, 16'h00C8);
    tab_item(OP_CELL, 16'h0001);
    tab_item(OP_CELL, 16'hFFFF);
    tab_item(OP_CELL, 16'h7FFF);
    tab_item(OP_CELL, 16'h8000);
    tab_item(OP_CELL, 16'h0100);
    tab_item(OP_CELL, 16'hFF00);
    tab_item(OP_FLUSH, 16'h0000);
    tab_item(OP_FLUSH, 16'h0000);
    tab_item(OP_FLUSH, 16'h0000);
    // oversized row count, clipped to the tallest grid, fed three rows then aborted
    tab_write(REG_ROWS, 16'h07FF);
    tab_write(REG_COLS, 16'd2);
    tab_item(OP_CELL, 16'h0300);
    tab_item(OP_CELL, 16'hFD00);
    tab_item(OP_CELL, 16'h7FFF);
    tab_item(OP_CELL, 16'h0080);
    tab_item(OP_FLUSH, 16'h0000);               // grid far from complete
    tab_item(OP_CELL, 16'h8000);
    tab_item(OP_CELL, 16'h1000);
    tab_write(REG_ROWS, 16'd2);                 // aborts the tall sweep

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (opening_rows[i]) begin
      if (opening_rows[i].is_write) begin
        write_reg(opening_rows[i].reg_idx, opening_rows[i].data);
      end else begin
        push_item(opening_rows[i].op, opening_rows[i].data, opening_rows[i].pinned,
                  opening_rows[i].want);
      end
    end

    // small grids with random settings, some sweeps cut short or resumed
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      quiet = (random_items > QUIET_AFTER);
      case ($urandom_range(0, 5))
        0: bnd = 16'h7FFF;
        1: bnd = 16'h8000;
        default: bnd = 16'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0: rows_w = 16'($urandom_range(0, 1));
        1: rows_w = {5'($urandom), 11'($urandom_range(2, 6))};
        default: rows_w = 16'($urandom_range(2, 8));
      endcase
      case ($urandom_range(0, 9))
        0: cols_w = 16'($urandom_range(0, 1));
        1: cols_w = {5'($urandom), 11'($urandom_range(2, 7))};
        default: cols_w = 16'($urandom_range(2, 9));
      endcase
      resize = ($urandom_range(0, 3) != 0);
      run_phase(bnd, rows_w, cols_w, resize, $urandom_range(1, 2),
                ($urandom_range(0, 4) == 0), n);
      random_items += n;
    end

    quiet = 1;
    drain_results();

    $display("run covered %0d slave transfers and %0d checked results over %0d whole sweeps",
             in_transfers, out_transfers, sweeps_closed);
    $display("grids from 2x2 to 8x9, a clipped tall grid, boundary extremes, aborts and noise");
    if (mismatches == 0 && pending_cells.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results never seen", mismatches, pending_cells.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/jfps_pkg.sv
rtl/jfps_ram.sv
rtl/jacobi_five_point_sweep.sv
tb/sv/tb_jacobi_five_point_sweep.sv
